// ===== src/alc_pkg.sv =====
// shared types and constants for the array list with cursor
`default_nettype none

package alc_pkg;

   localparam int DEFAULT_CAPACITY = 128;
   localparam int DATA_W           = 32;
   localparam int COUNT_W          = 8;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIRST  = 2'd1,
      CMD_NEXT   = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_END       = 2'd2,
      ST_NO_CURSOR = 2'd3
   } status_code_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_FIRST,
      RD_NEXT,
      RD_CUR,
      RD_SHIFT
   } rd_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_CAPT,
      S_SH_RD,
      S_SH_WR,
      S_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic            accept;
      logic            set_status;
      status_code_type status_code;
      rd_sel_type      rd_sel;
      logic            capture;
      logic            sh_wr;
      logic            respond;
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      cmd_code_type cmd;
      logic         full;
      logic         empty;
      logic         at_end;
      logic         no_cursor;
      logic         shift_more;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/alc_ctrl.sv =====
// command sequencer for the array list with cursor
`default_nettype none

module alc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire alc_pkg::stat_type stat,
   output alc_pkg::ctrl_type      ctrl,
   output logic                   busy
);

   alc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alc_pkg::S_IDLE: begin
            if (start) state_in = alc_pkg::S_EVAL;
         end
         alc_pkg::S_EVAL: begin
            case (stat.cmd)
               alc_pkg::CMD_FIRST:  state_in = stat.empty ? alc_pkg::S_RESP : alc_pkg::S_CAPT;
               alc_pkg::CMD_NEXT:   state_in = stat.at_end ? alc_pkg::S_RESP : alc_pkg::S_CAPT;
               alc_pkg::CMD_REMOVE: state_in = stat.no_cursor ? alc_pkg::S_RESP : alc_pkg::S_CAPT;
               default:             state_in = alc_pkg::S_RESP;
            endcase
         end
         alc_pkg::S_CAPT: begin
            state_in = (stat.cmd == alc_pkg::CMD_REMOVE) ? alc_pkg::S_SH_RD : alc_pkg::S_RESP;
         end
         alc_pkg::S_SH_RD: begin
            state_in = stat.shift_more ? alc_pkg::S_SH_WR : alc_pkg::S_RESP;
         end
         alc_pkg::S_SH_WR: state_in = alc_pkg::S_SH_RD;
         alc_pkg::S_RESP:  state_in = alc_pkg::S_IDLE;
         default:          state_in = alc_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl             = '0;
      ctrl.status_code = alc_pkg::ST_OK;
      ctrl.rd_sel      = alc_pkg::RD_NONE;
      busy             = (state_ff != alc_pkg::S_IDLE);
      case (state_ff)
         alc_pkg::S_IDLE: begin
            ctrl.accept = start;
         end
         alc_pkg::S_EVAL: begin
            case (stat.cmd)
               alc_pkg::CMD_INSERT: begin
                  if (stat.full) begin
                     ctrl.set_status  = 1'b1;
                     ctrl.status_code = alc_pkg::ST_FULL;
                  end
               end
               alc_pkg::CMD_FIRST: begin
                  if (stat.empty) begin
                     ctrl.set_status  = 1'b1;
                     ctrl.status_code = alc_pkg::ST_END;
                  end else begin
                     ctrl.rd_sel = alc_pkg::RD_FIRST;
                  end
               end
               alc_pkg::CMD_NEXT: begin
                  if (stat.at_end) begin
                     ctrl.set_status  = 1'b1;
                     ctrl.status_code = alc_pkg::ST_END;
                  end else begin
                     ctrl.rd_sel = alc_pkg::RD_NEXT;
                  end
               end
               alc_pkg::CMD_REMOVE: begin
                  if (stat.no_cursor) begin
                     ctrl.set_status  = 1'b1;
                     ctrl.status_code = alc_pkg::ST_NO_CURSOR;
                  end else begin
                     ctrl.rd_sel = alc_pkg::RD_CUR;
                  end
               end
               default: ;
            endcase
         end
         alc_pkg::S_CAPT: begin
            ctrl.capture = 1'b1;
         end
         alc_pkg::S_SH_RD: begin
            if (stat.shift_more) ctrl.rd_sel = alc_pkg::RD_SHIFT;
         end
         alc_pkg::S_SH_WR: begin
            ctrl.sh_wr = 1'b1;
         end
         alc_pkg::S_RESP: begin
            ctrl.respond = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/alc_dpath.sv =====
// entry memory, count, cursor and result registers of the array list
`default_nettype none

module alc_dpath #(
   parameter int CAPACITY = alc_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire alc_pkg::ctrl_type                ctrl,
   input  wire logic [1:0]                       req_command,
   input  wire logic signed [alc_pkg::DATA_W-1:0] req_data_in,
   output alc_pkg::stat_type                     stat,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic signed [alc_pkg::DATA_W-1:0]     rsp_data_out,
   output logic [alc_pkg::COUNT_W-1:0]           rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = alc_pkg::DATA_W;
   localparam int NW = alc_pkg::COUNT_W;

   logic [DW-1:0] mem [CAPACITY];

   // pos_ff is the cursor plus one, so zero means before the first entry
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           pos_ff, pos_in;
   logic [AW-1:0]           idx_ff, idx_in;
   alc_pkg::cmd_code_type   cmd_ff;
   logic [DW-1:0]           data_ff;
   alc_pkg::status_code_type status_ff, status_in;
   logic [DW-1:0]           hold_ff, hold_in;
   logic [DW-1:0]           rd_data_ff;

   logic                    rsp_valid_ff;
   alc_pkg::status_code_type rsp_status_ff;
   logic [DW-1:0]           rsp_data_ff;
   logic [NW-1:0]           rsp_count_ff;

   logic [CW-1:0]           idx_plus;
   logic [CW-1:0]           pos_minus;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DW-1:0]           wr_data;
   logic                    commit_ins;
   logic                    commit_rm;
   logic [CW+NW-1:0]        count_wide;

   assign idx_plus  = CW'(idx_ff) + CW'(1);
   assign pos_minus = pos_ff - CW'(1);

   assign stat.cmd        = cmd_ff;
   assign stat.full       = (count_ff == CW'(CAPACITY));
   assign stat.empty      = (count_ff == '0);
   assign stat.at_end     = (pos_ff >= count_ff);
   assign stat.no_cursor  = (pos_ff == '0) || (pos_ff > count_ff);
   assign stat.shift_more = (idx_plus < count_ff);

   assign commit_ins = ctrl.respond && (status_ff == alc_pkg::ST_OK)
                       && (cmd_ff == alc_pkg::CMD_INSERT);
   assign commit_rm  = ctrl.respond && (status_ff == alc_pkg::ST_OK)
                       && (cmd_ff == alc_pkg::CMD_REMOVE);

   // read port select
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      pos_in  = pos_ff;
      idx_in  = idx_ff;
      case (ctrl.rd_sel)
         alc_pkg::RD_FIRST: begin
            rd_addr = '0;
            pos_in  = CW'(1);
         end
         alc_pkg::RD_NEXT: begin
            rd_addr = AW'(pos_ff);
            pos_in  = pos_ff + CW'(1);
         end
         alc_pkg::RD_CUR: begin
            rd_addr = AW'(pos_minus);
            idx_in  = AW'(pos_minus);
         end
         alc_pkg::RD_SHIFT: begin
            rd_addr = AW'(idx_plus);
         end
         default: rd_en = 1'b0;
      endcase
      if (ctrl.sh_wr) idx_in = AW'(idx_plus);
      if (commit_rm) pos_in = pos_minus;
   end

   // write port: append on insert, move down during a remove
   always_comb begin
      wr_en   = commit_ins || ctrl.sh_wr;
      wr_addr = ctrl.sh_wr ? idx_ff : AW'(count_ff);
      wr_data = ctrl.sh_wr ? rd_data_ff : data_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (commit_ins) count_in = count_ff + CW'(1);
      else if (commit_rm) count_in = count_ff - CW'(1);
   end

   always_comb begin
      status_in = status_ff;
      hold_in   = hold_ff;
      if (ctrl.accept) begin
         status_in = alc_pkg::ST_OK;
         hold_in   = '0;
      end
      if (ctrl.set_status) status_in = ctrl.status_code;
      if (ctrl.capture) hold_in = rd_data_ff;
   end

   // count is reported modulo 256
   assign count_wide = {{NW{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= ctrl.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cmd_ff  <= alc_pkg::cmd_code_type'(req_command);
         data_ff <= req_data_in;
      end
      idx_ff    <= idx_in;
      status_ff <= status_in;
      hold_ff   <= hold_in;
      if (ctrl.respond) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= hold_ff;
         rsp_count_ff  <= count_wide[NW-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= count_ff)
      else $error("cursor beyond last entry");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.sh_wr |-> (idx_plus < count_ff))
      else $error("shift write outside stored entries");

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      ctrl.respond |=> !ctrl.respond)
      else $error("two results from one request");

endmodule

`default_nettype wire

// ===== src/array_list_with_cursor_top.sv =====
// top level of the array list with cursor
//
// A fixed-capacity list of 32-bit words with a read cursor, stored in a single
// memory with one write port and one registered read port. A request is taken
// when start is high and busy is low; its result appears on the rsp_ ports for
// exactly one cycle with rsp_valid high and must be taken then. Insert, a
// rejected request (full, end of list, no cursor) and go-to-first/next each
// give their result in the first cycle that busy is low. Remove moves every
// later entry down through that one memory port, reading it and then writing
// it one place lower, so it occupies the block longer the more entries lie
// behind the cursor. No clearing pass follows reset; busy is low from the
// first cycle after reset.
`default_nettype none

module array_list_with_cursor_top #(
   parameter int CAPACITY = alc_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_command,
   input  wire logic signed [alc_pkg::DATA_W-1:0] req_data_in,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic signed [alc_pkg::DATA_W-1:0]      rsp_data_out,
   output logic [alc_pkg::COUNT_W-1:0]            rsp_count
);

   alc_pkg::ctrl_type ctrl;
   alc_pkg::stat_type stat;

   alc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   alc_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .req_command  (req_command),
      .req_data_in  (req_data_in),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_count    (rsp_count)
   );

endmodule

`default_nettype wire

// ===== bench/array_list_with_cursor_checker.sv =====
// checker for the array list with cursor: tracks the list, predicts each result and compares
module array_list_with_cursor_checker #(
   parameter int CAPACITY = alc_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [1:0]                        req_command,
   input  wire logic signed [alc_pkg::DATA_W-1:0] req_data_in,
   input  wire logic                              rsp_valid,
   input  wire logic [1:0]                        rsp_status,
   input  wire logic signed [alc_pkg::DATA_W-1:0] rsp_data_out,
   input  wire logic [alc_pkg::COUNT_W-1:0]       rsp_count,
   output int                                     mismatch_count,
   output int                                     pending_count,
   output int                                     checked_count,
   output int                                     full_seen,
   output int                                     no_cursor_seen,
   output int                                     removed_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = alc_pkg::DATA_W;
   localparam int NW = alc_pkg::COUNT_W;

   typedef struct packed {
      alc_pkg::status_code_type status;
      logic signed [DW-1:0]     data;
      logic [NW-1:0]            count;
   } list_result_type;

   logic signed [DW-1:0] shadow_entries [CAPACITY];
   int                   shadow_count;
   int                   shadow_cursor;
   list_result_type      expected_results [$];

   function automatic list_result_type apply_command(alc_pkg::cmd_code_type cmd,
                                                     logic signed [DW-1:0] word);
      list_result_type r;
      r.status = alc_pkg::ST_OK;
      r.data   = '0;
      case (cmd)
         alc_pkg::CMD_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               r.status = alc_pkg::ST_FULL;
            end else begin
               shadow_entries[shadow_count] = word;
               shadow_count++;
            end
         end
         alc_pkg::CMD_FIRST: begin
            if (shadow_count == 0) begin
               r.status = alc_pkg::ST_END;
            end else begin
               shadow_cursor = 0;
               r.data = shadow_entries[0];
            end
         end
         alc_pkg::CMD_NEXT: begin
            // from before the first entry this lands on entry 0
            if (shadow_cursor + 1 >= shadow_count) begin
               r.status = alc_pkg::ST_END;
            end else begin
               shadow_cursor++;
               r.data = shadow_entries[shadow_cursor];
            end
         end
         default: begin
            if (shadow_cursor < 0 || shadow_cursor >= shadow_count) begin
               r.status = alc_pkg::ST_NO_CURSOR;
            end else begin
               r.data = shadow_entries[shadow_cursor];
               for (int i = shadow_cursor; i + 1 < shadow_count; i++)
                  shadow_entries[i] = shadow_entries[i + 1];
               shadow_count--;
               shadow_cursor--;
            end
         end
      endcase
      r.count = NW'(shadow_count);
      return r;
   endfunction

   task automatic note_mismatch(string what, list_result_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: status %0d/%0d data %h/%h count %0d/%0d (expected/actual)",
                  $realtime, what, want.status, rsp_status, want.data, rsp_data_out,
                  want.count, rsp_count);
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
      full_seen      = 0;
      no_cursor_seen = 0;
      removed_seen   = 0;
      shadow_count   = 0;
      shadow_cursor  = -1;
   end

   always @(posedge clock) begin
      list_result_type want;
      list_result_type pred;
      if (reset) begin
         shadow_count  = 0;
         shadow_cursor = -1;
         expected_results.delete();
      end else begin
         // pop before push: a result never belongs to the request taken at the same edge
         if (rsp_valid) begin
            checked_count++;
            if (expected_results.size() == 0) begin
               want = '0;
               note_mismatch("result with no request outstanding", want);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status || rsp_data_out !== want.data ||
                   rsp_count !== want.count)
                  note_mismatch($sformatf("mismatch on result %0d", checked_count), want);
            end
         end
         if (start && !busy) begin
            pred = apply_command(alc_pkg::cmd_code_type'(req_command), req_data_in);
            if (pred.status == alc_pkg::ST_FULL)
               full_seen++;
            if (pred.status == alc_pkg::ST_NO_CURSOR)
               no_cursor_seen++;
            if (alc_pkg::cmd_code_type'(req_command) == alc_pkg::CMD_REMOVE &&
                pred.status == alc_pkg::ST_OK)
               removed_seen++;
            expected_results.push_back(pred);
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// ===== bench/array_list_with_cursor_top_test.sv =====
// testbench top for the array list with cursor: stimulus, block, checker and verdict
module array_list_with_cursor_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [1:0]                        req_command;
   logic signed [alc_pkg::DATA_W-1:0] req_data_in;
   logic                              rsp_valid;
   logic [1:0]                        rsp_status;
   logic signed [alc_pkg::DATA_W-1:0] rsp_data_out;
   logic [alc_pkg::COUNT_W-1:0]       rsp_count;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int full_seen;
   int no_cursor_seen;
   int removed_seen;
   int sent_count;
   bit steady;

   array_list_with_cursor_top u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_count    (rsp_count)
   );

   array_list_with_cursor_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_data_in    (req_data_in),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_count      (rsp_count),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .full_seen      (full_seen),
      .no_cursor_seen (no_cursor_seen),
      .removed_seen   (removed_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // start stays high from one request to the next unless an idle cycle falls between
   task automatic send_request(alc_pkg::cmd_code_type cmd, logic [alc_pkg::DATA_W-1:0] word);
      while (!steady && $urandom_range(99) < 16) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_data_in <= word;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   task automatic run_mix(int n, int w_insert, int w_first, int w_next, int w_remove);
      int                    pick;
      alc_pkg::cmd_code_type cmd;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(w_insert + w_first + w_next + w_remove - 1);
         if (pick < w_insert)
            cmd = alc_pkg::CMD_INSERT;
         else if (pick < w_insert + w_first)
            cmd = alc_pkg::CMD_FIRST;
         else if (pick < w_insert + w_first + w_next)
            cmd = alc_pkg::CMD_NEXT;
         else
            cmd = alc_pkg::CMD_REMOVE;
         send_request(cmd, $urandom());
      end
   endtask

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_command = alc_pkg::CMD_INSERT;
      req_data_in = '0;
      sent_count  = 0;
      steady      = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corner cases
      send_request(alc_pkg::CMD_REMOVE, 32'h0000_0000);
      send_request(alc_pkg::CMD_NEXT,   32'hFFFF_FFFF);
      send_request(alc_pkg::CMD_FIRST,  32'h0000_0000);
      send_request(alc_pkg::CMD_INSERT, 32'h7FFF_FFFF);
      send_request(alc_pkg::CMD_INSERT, 32'h8000_0000);
      send_request(alc_pkg::CMD_INSERT, 32'h0000_0000);
      send_request(alc_pkg::CMD_INSERT, 32'hFFFF_FFFF);
      // cursor still before the first entry
      send_request(alc_pkg::CMD_REMOVE, 32'h0000_0000);
      send_request(alc_pkg::CMD_NEXT,   32'h0000_0000);
      send_request(alc_pkg::CMD_NEXT,   32'h0000_0000);
      // remove from the middle, then walk to the end and past it
      send_request(alc_pkg::CMD_REMOVE, 32'h0000_0000);
      send_request(alc_pkg::CMD_NEXT,   32'h0000_0000);
      send_request(alc_pkg::CMD_NEXT,   32'h0000_0000);
      send_request(alc_pkg::CMD_NEXT,   32'h0000_0000);
      send_request(alc_pkg::CMD_REMOVE, 32'h0000_0000);
      send_request(alc_pkg::CMD_FIRST,  32'h0000_0000);
      send_request(alc_pkg::CMD_REMOVE, 32'h0000_0000);
      send_request(alc_pkg::CMD_REMOVE, 32'h0000_0000);
      send_request(alc_pkg::CMD_INSERT, 32'h5555_AAAA);
      send_request(alc_pkg::CMD_INSERT, 32'hAAAA_5555);

      // fill past capacity, scan, drain, then free mix
      run_mix(180, 88, 4, 4, 4);
      steady = 1'b1;
      run_mix(60, 0, 10, 80, 10);
      run_mix(100, 5, 5, 45, 45);
      steady = 1'b0;
      run_mix(160, 5, 5, 45, 45);
      run_mix(200, 40, 20, 20, 20);

      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (300) @(posedge clock);

      $display("sent %0d requests and checked %0d results", sent_count, checked_count);
      $display("list full %0d times, %0d entries removed, %0d removes without a cursor",
               full_seen, removed_seen, no_cursor_seen);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
src/alc_pkg.sv
src/alc_ctrl.sv
src/alc_dpath.sv
src/array_list_with_cursor_top.sv
bench/array_list_with_cursor_checker.sv
bench/array_list_with_cursor_top_test.sv
